@@ rtl/urx_pkg.sv @@
package urx_pkg;

  // serial frame
  localparam int unsigned DATA_BITS      = 8;
  localparam int unsigned BIT_IDX_W      = $clog2(DATA_BITS);
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned BIT_PERIOD_W   = 16;
  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd434;

  // stream widths
  localparam int unsigned S_TDATA_W      = 8;
  localparam int unsigned M_TDATA_W      = 16;

  // result queue in front of the master port
  localparam int unsigned OUT_DEPTH      = 4;
  localparam int unsigned OUT_PTR_W      = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

  // finished byte from the receiver
  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
  } urx_push_t;

  // per-tick status from the byte fifo
  typedef struct packed {
    logic pop;
    logic avail;
    logic drop;
  } urx_fifo_stat_t;

  // one result, read_data in the lowest bits
  typedef struct packed {
    logic              byte_dropped;
    logic              data_available;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
  } urx_result_t;

  localparam int unsigned RESULT_W = $bits(urx_result_t);

endpackage

@@ rtl/urx_rx.sv @@
module urx_rx #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                line_i,
  input  logic [urx_pkg::BIT_PERIOD_W-1:0]    bit_period_i,
  output urx_pkg::urx_push_t                  push_o
);
  import urx_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_START = 3'b010,
    PH_DATA  = 3'b100
  } urx_phase_e;

  localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(DATA_BITS - 1);

  urx_phase_e             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [BIT_IDX_W-1:0]   idx_q, idx_d;
  logic [BYTE_W-1:0]      shift_q, shift_d;
  logic                   line_prev_q;
  logic [COUNT_WIDTH-1:0] cnt_full, cnt_half;
  logic                   cnt_more;
  logic [BYTE_W-1:0]      shift_bit;

  // counter reload values and end-of-wait test
  assign cnt_full  = COUNT_WIDTH'(bit_period_i);
  assign cnt_half  = COUNT_WIDTH'(bit_period_i >> 1);
  assign cnt_more  = |cnt_q[COUNT_WIDTH-1:1];
  assign shift_bit = shift_q | (BYTE_W'(line_i) << idx_q);

  // receive sequencer
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    push_o  = '0;
    if (en_i) begin
      case (phase_q)
        PH_START: begin
          if (cnt_more) begin
            cnt_d = cnt_q - COUNT_WIDTH'(1);
          end else if (!line_i) begin
            shift_d = '0;
            idx_d   = '0;
            phase_d = PH_DATA;
            cnt_d   = cnt_full;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_DATA: begin
          if (cnt_more) begin
            cnt_d = cnt_q - COUNT_WIDTH'(1);
          end else begin
            shift_d = shift_bit;
            if (idx_q == LAST_IDX) begin
              push_o.push = 1'b1;
              push_o.data = shift_bit;
              idx_d       = '0;
              phase_d     = PH_IDLE;
            end else begin
              idx_d = idx_q + BIT_IDX_W'(1);
              cnt_d = cnt_full;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (line_prev_q && !line_i) begin
            phase_d = PH_START;
            cnt_d   = cnt_half;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      shift_q     <= '0;
      line_prev_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      if (en_i) begin
        line_prev_q <= line_i;
      end
    end
  end

endmodule

@@ rtl/urx_fifo.sv @@
module urx_fifo #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          pop_req_i,
  input  urx_pkg::urx_push_t            push_i,
  output urx_pkg::urx_fifo_stat_t       stat_o,
  output logic [urx_pkg::BYTE_W-1:0]    rd_data_o
);
  import urx_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [BYTE_W-1:0] mem_q [FIFO_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  rp_q, wp_q, rp_d, wp_d, rp_inc, wp_inc;
  logic              pop, full, wr;

  // ring pointer arithmetic
  assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
  assign wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);

  // pop is served from the fifo as it stood before this tick
  assign pop  = en_i && pop_req_i && (rp_q != wp_q);
  assign rp_d = pop ? rp_inc : rp_q;

  // push sees the pointer after the pop; one slot stays empty
  assign full = (wp_inc == rp_d);
  assign wr   = en_i && push_i.push && !full;
  assign wp_d = wr ? wp_inc : wp_q;

  assign stat_o.pop   = pop;
  assign stat_o.avail = (rp_d != wp_d);
  assign stat_o.drop  = en_i && push_i.push && full;

  // byte store: one write and one registered read per cycle, never the same entry
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= push_i.data;
    end
    if (pop) begin
      rd_data_q <= mem_q[rp_q];
    end
  end

  assign rd_data_o = rd_data_q;

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      wp_q <= '0;
    end else begin
      rp_q <= rp_d;
      wp_q <= wp_d;
    end
  end

endmodule

@@ rtl/urx_out_q.sv @@
module urx_out_q (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  urx_pkg::urx_result_t              push_data_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output urx_pkg::urx_result_t              data_o,
  output logic [urx_pkg::OUT_CNT_W-1:0]     cnt_o
);
  import urx_pkg::*;

  urx_result_t          entry_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wp_q, rp_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rp_q];
  assign cnt_o   = cnt_q;

  // result storage, space is guaranteed by the input credit
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rp_q <= rp_q + OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(pop);
    end
  end

endmodule

@@ rtl/uart_rx_deserializer_fifo.sv @@
// 8N1 serial receiver with a byte fifo, LSB first.
// Slave stream: one transfer per clock tick of the serial line; tdata carries
// the sampled line level and a read request for the oldest byte.
// Master stream: one result transfer per input transfer, in order, carrying
// the popped byte, its valid flag, the fifo-not-empty flag and a pulse when a
// finished byte was lost to a full fifo.
// cfg_we_i/cfg_wdata_i write the bit period in clock ticks; write it only
// while no transfer is in flight.
// A result passes the status stage and then the result queue on its way to the
// master port. Throughput: one transfer per cycle while s_axis_tready is high;
// a tick's receiver step, pop and push all complete in its accepting cycle.
// s_axis_tready comes from registers only: it stays high while fewer than four
// results are pending, so a stalled receiver lets up to four more input
// transfers in before input is held off; nothing is dropped on a stall.
// Reset clears the receiver, the fifo pointers and the result queue and
// loads a bit period of 434; the byte store itself needs no clearing.
module uart_rx_deserializer_fifo #(
  parameter int unsigned FIFO_DEPTH  = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [urx_pkg::BIT_PERIOD_W-1:0]     cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] rx_line, [1] read_req, [7:2] zero
  input  logic [urx_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] read_data, [8] read_valid, [9] data_available,
  // [10] byte_dropped, [15:11] zero
  output logic [urx_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
  import urx_pkg::*;

  localparam logic [OUT_CNT_W-1:0] OCC_LIMIT = OUT_CNT_W'(OUT_DEPTH);

  logic [BIT_PERIOD_W-1:0] bit_period_q;
  logic                    s_xfer;
  urx_push_t               push;
  urx_fifo_stat_t          stat;
  logic [BYTE_W-1:0]       rd_data;
  logic                    p1_v_q;
  urx_fifo_stat_t          p1_stat_q;
  urx_result_t             p1_res, out_res;
  logic [OUT_CNT_W-1:0]    q_cnt, occ;

  // bit period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BIT_PERIOD_RST;
    end else if (cfg_we_i) begin
      bit_period_q <= cfg_wdata_i;
    end
  end

  // input credit: results in flight plus queued
  assign occ           = q_cnt + OUT_CNT_W'(p1_v_q);
  assign s_axis_tready = (occ < OCC_LIMIT);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  urx_rx #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s_xfer),
    .line_i       (s_axis_tdata[0]),
    .bit_period_i (bit_period_q),
    .push_o       (push)
  );

  urx_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s_xfer),
    .pop_req_i (s_axis_tdata[1]),
    .push_i    (push),
    .stat_o    (stat),
    .rd_data_o (rd_data)
  );

  // status stage, lines up with the store's registered read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= s_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      p1_stat_q <= stat;
    end
  end

  // assemble the result, zero byte when nothing was popped
  assign p1_res.read_data      = p1_stat_q.pop ? rd_data : '0;
  assign p1_res.read_valid     = p1_stat_q.pop;
  assign p1_res.data_available = p1_stat_q.avail;
  assign p1_res.byte_dropped   = p1_stat_q.drop;

  urx_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p1_v_q),
    .push_data_i (p1_res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res),
    .cnt_o       (q_cnt)
  );

  assign m_axis_tdata = {(M_TDATA_W - RESULT_W)'(0), out_res};

endmodule

@@ rtl/urx_checker.sv @@
module urx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // every input transfer is followed by a valid result at the master port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("result missing after input transfer");

  // no pop means a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("byte shown without a pop");

  // a dropped byte means the fifo is full, so not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9])
    else $error("drop reported with empty fifo");

endmodule

bind uart_rx_deserializer_fifo urx_checker u_urx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
